// ===== rtl/least_loaded_server_table_unit_assert.svh =====
`ifndef LEAST_LOADED_SERVER_TABLE_UNIT_ASSERT_SVH
`define LEAST_LOADED_SERVER_TABLE_UNIT_ASSERT_SVH

// Checks that a condition in a cycle brings a consequence in the same cycle.
`define LLST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition in a cycle brings a consequence in the next cycle.
`define LLST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/llst_pkg.sv =====
package llst_pkg;

    localparam logic [1:0] MODE_UPSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_PICK   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        handle;
        logic signed [31:0] delta;
        logic [31:0]        new_cur_count;
        logic [31:0]        new_max_count;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_handle;
        logic [31:0] out_cur_count;
        logic [31:0] out_max_count;
        logic        table_empty;
    } out_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] cur_count;
        logic [31:0] max_count;
    } entry_t;

    typedef struct packed {
        logic match_found;
        logic free_found;
        logic best_found;
    } scan_flags_t;

endpackage

// ===== rtl/least_loaded_server_table_unit.sv =====
// Channel | valid     | stall     | payload
// request | req_valid | req_stall | req (llst_pkg::in_t)
// result  | rsp_valid | rsp_stall | rsp (llst_pkg::out_t)
//
// An accepted beat runs a sequential scan of the entry memory, one read per cycle,
// and then a write-back step that loads the result register.
// A new beat is accepted only while the sequencer is idle.
// Reset clears all valid bits and the entry count; the memory itself is not cleared.
// A stalled result holds the sequencer before its write-back until the result is taken.
module least_loaded_server_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  llst_pkg::in_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output llst_pkg::out_t rsp
);
    import llst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic [CW-1:0]    used_reg;
    logic [CW-1:0]    used_next;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic             ev_vld_reg;
    logic             ev_vld_next;
    logic [IW-1:0]    ev_idx_reg;
    in_t              item_reg;
    logic             rsp_vld_reg;
    out_t             rsp_reg;

    logic             accept;
    logic             scan_clr;
    logic             exec_go;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;
    scan_flags_t      flags;
    logic [IW-1:0]    match_idx;
    logic [IW-1:0]    free_idx;
    entry_t           match_ent;
    entry_t           best_ent;
    out_t             res;
    logic [32:0]      sum;
    logic [31:0]      mag;
    logic [31:0]      upd_cur;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign scan_clr  = accept;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_vld_reg || !rsp_stall);

    llst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    llst_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (scan_clr),
        .ev_vld    (ev_vld_reg),
        .ev_idx    (ev_idx_reg),
        .ev_valid  (valid_reg[ev_idx_reg]),
        .ev_ent    (ram_rdata),
        .key       (item_reg.handle),
        .flags     (flags),
        .match_idx (match_idx),
        .free_idx  (free_idx),
        .match_ent (match_ent),
        .best_ent  (best_ent)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ev_vld_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == CW'(SLOTS))
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    ev_vld_next = 1'b1;
                    cnt_next    = cnt_reg + CW'(1);
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign sum = {1'b0, match_ent.cur_count} + {1'b0, item_reg.delta};
    assign mag = ~item_reg.delta + 32'd1;

    always_comb
    begin
        if (item_reg.delta[31])
        begin
            upd_cur = (match_ent.cur_count > mag) ? (match_ent.cur_count - mag) : 32'd0;
        end
        else
        begin
            upd_cur = sum[32] ? CNT_MAX : sum[31:0];
        end
    end

    always_comb
    begin
        res            = '0;
        res.status     = ST_MISS;
        res.out_handle = item_reg.handle;
        ram_we         = 1'b0;
        ram_waddr      = match_idx;
        ram_wdata      = match_ent;
        valid_next     = valid_reg;
        used_next      = used_reg;
        case (item_reg.mode)
            MODE_UPSERT:
            begin
                ram_wdata.handle    = item_reg.handle;
                ram_wdata.cur_count = item_reg.new_cur_count;
                ram_wdata.max_count = item_reg.new_max_count;
                if (flags.match_found || flags.free_found)
                begin
                    ram_we            = 1'b1;
                    res.status        = ST_OK;
                    res.out_cur_count = item_reg.new_cur_count;
                    res.out_max_count = item_reg.new_max_count;
                    if (!flags.match_found)
                    begin
                        ram_waddr            = free_idx;
                        valid_next[free_idx] = 1'b1;
                        used_next            = used_reg + CW'(1);
                    end
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            MODE_REMOVE:
            begin
                if (flags.match_found)
                begin
                    res.status            = ST_OK;
                    res.out_cur_count     = match_ent.cur_count;
                    res.out_max_count     = match_ent.max_count;
                    valid_next[match_idx] = 1'b0;
                    used_next             = used_reg - CW'(1);
                end
            end
            MODE_UPDATE:
            begin
                ram_wdata.cur_count = upd_cur;
                if (flags.match_found)
                begin
                    ram_we            = 1'b1;
                    res.status        = ST_OK;
                    res.out_cur_count = upd_cur;
                    res.out_max_count = match_ent.max_count;
                end
            end
            MODE_PICK:
            begin
                if (flags.best_found)
                begin
                    res.status        = ST_OK;
                    res.out_handle    = best_ent.handle;
                    res.out_cur_count = best_ent.cur_count;
                    res.out_max_count = best_ent.max_count;
                end
                else
                begin
                    res.out_handle = 32'd0;
                end
            end
            default:
            begin
                res.status = ST_MISS;
            end
        endcase
        res.table_empty = (used_next == '0);
        if (!exec_go)
        begin
            ram_we     = 1'b0;
            valid_next = valid_reg;
            used_next  = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            used_reg    <= '0;
            valid_reg   <= '0;
            ev_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            used_reg   <= used_next;
            valid_reg  <= valid_next;
            ev_vld_reg <= ev_vld_next;
            if (exec_go)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ev_idx_reg <= cnt_reg[IW-1:0];
        if (accept)
        begin
            item_reg <= req;
        end
        if (exec_go)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

`include "least_loaded_server_table_unit_assert.svh"

    `LLST_ASSERT_SAME(a_used_matches_valid, clk, rst_n, 1'b1,
        $countones(valid_reg) == used_reg, "Entry count differs from the valid bits.")
    `LLST_ASSERT_SAME(a_full_only_when_full, clk, rst_n, exec_go && (res.status == ST_FULL),
        used_reg == CW'(SLOTS), "Table reported full with a free slot.")
    `LLST_ASSERT_NEXT(a_exec_loads_result, clk, rst_n, exec_go,
        rsp_vld_reg && (state_reg == S_IDLE), "Write-back did not load the result register.")
    `LLST_ASSERT_SAME(a_scan_bounded, clk, rst_n, 1'b1,
        cnt_reg <= CW'(SLOTS), "Scan counter ran past the last slot.")

endmodule

// ===== rtl/llst_ram.sv =====
module llst_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/llst_scan.sv =====
module llst_scan #(
    parameter int SLOTS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       clr,
    input  logic                                       ev_vld,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ev_idx,
    input  logic                                       ev_valid,
    input  llst_pkg::entry_t                           ev_ent,
    input  logic [31:0]                                key,
    output llst_pkg::scan_flags_t                      flags,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] match_idx,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] free_idx,
    output llst_pkg::entry_t                           match_ent,
    output llst_pkg::entry_t                           best_ent
);
    import llst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    scan_flags_t   flags_reg;
    logic [IW-1:0] match_idx_reg;
    logic [IW-1:0] free_idx_reg;
    entry_t        match_ent_reg;
    entry_t        best_ent_reg;
    logic          hit_match;
    logic          hit_free;
    logic          hit_best;

    assign hit_match = ev_vld && ev_valid && !flags_reg.match_found && (ev_ent.handle == key);
    assign hit_free  = ev_vld && !ev_valid && !flags_reg.free_found;
    assign hit_best  = ev_vld && ev_valid && (ev_ent.cur_count < ev_ent.max_count) &&
                       (!flags_reg.best_found ||
                        (ev_ent.cur_count < best_ent_reg.cur_count) ||
                        ((ev_ent.cur_count == best_ent_reg.cur_count) &&
                         (ev_ent.handle < best_ent_reg.handle)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clr)
        begin
            flags_reg <= '0;
        end
        else
        begin
            if (hit_match)
            begin
                flags_reg.match_found <= 1'b1;
            end
            if (hit_free)
            begin
                flags_reg.free_found <= 1'b1;
            end
            if (hit_best)
            begin
                flags_reg.best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_match)
        begin
            match_idx_reg <= ev_idx;
            match_ent_reg <= ev_ent;
        end
        if (hit_free)
        begin
            free_idx_reg <= ev_idx;
        end
        if (hit_best)
        begin
            best_ent_reg <= ev_ent;
        end
    end

    assign flags     = flags_reg;
    assign match_idx = match_idx_reg;
    assign free_idx  = free_idx_reg;
    assign match_ent = match_ent_reg;
    assign best_ent  = best_ent_reg;

endmodule
